### rtl/charge_time_to_full_estimator_macros.svh
// ----------------------------------------------------------------------------
// Charge time-to-full estimator assertion macros
// Concurrent assertion wrappers. Define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef CHARGE_TIME_TO_FULL_ESTIMATOR_MACROS_SVH
`define CHARGE_TIME_TO_FULL_ESTIMATOR_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset
`define CTTE_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("charge estimator assertion failed");
// Check that a condition holds in the cycle after a trigger
`define CTTE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("charge estimator assertion failed");
`else
`define CTTE_ASSERT(lbl, prop)
`define CTTE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### rtl/ctte_pkg.sv
// ----------------------------------------------------------------------------
// Charge time-to-full estimator package
// Shared widths, register indexes, datapath operation codes and status type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ctte_pkg;

	localparam int FRACTION_BITS_DEF = 16;

	localparam int CUR_IN_W   = 20;
	localparam int PCT_W      = 7;
	localparam int TIME_W     = 32;
	localparam int CHG_W      = 48;
	localparam int WEIGHT_W   = 16;
	localparam int CAP_W      = 20;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_TIME   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CUR_WEIGHT = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_WEIGHT = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 8'd3;

	// Register reset values
	localparam logic [TIME_W-1:0]   MIN_TIME_RST = 32'd30000;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RST   = 16'd6554;
	localparam logic [CAP_W-1:0]    CAPACITY_RST = 20'd20000;

	// Datapath operations
	typedef logic [4:0] op_t;
	localparam op_t OP_NOP       = 5'd0;
	localparam op_t OP_LOAD      = 5'd1;
	localparam op_t OP_MUL_GATH  = 5'd2;
	localparam op_t OP_LOG       = 5'd3;
	localparam op_t OP_MUL_AC1   = 5'd4;
	localparam op_t OP_MUL_AC2   = 5'd5;
	localparam op_t OP_AC3       = 5'd6;
	localparam op_t OP_RDIV_GO   = 5'd7;
	localparam op_t OP_RDIV_TAKE = 5'd8;
	localparam op_t OP_RATE_SET  = 5'd9;
	localparam op_t OP_MUL_RM1   = 5'd10;
	localparam op_t OP_MUL_RM2   = 5'd11;
	localparam op_t OP_RATE_MIX  = 5'd12;
	localparam op_t OP_CDIV_GO   = 5'd13;
	localparam op_t OP_CUR_SAT   = 5'd14;
	localparam op_t OP_CDIV_TAKE = 5'd15;
	localparam op_t OP_FULL_CUR  = 5'd16;
	localparam op_t OP_SDIV_GO   = 5'd17;
	localparam op_t OP_SDIV_TAKE = 5'd18;
	localparam op_t OP_WQ_CAP    = 5'd19;
	localparam op_t OP_WQ_CALC   = 5'd20;
	localparam op_t OP_MUL_BL1   = 5'd21;
	localparam op_t OP_MUL_BL2   = 5'd22;
	localparam op_t OP_BLEND     = 5'd23;
	localparam op_t OP_FIN       = 5'd24;

	// Datapath status toward the controller
	typedef struct packed {
		logic charging;
		logic chg_before;
		logic ge_min;
		logic dt_nz;
		logic rate_zero;
		logic cur_zero;
		logic rate_usable;
		logic ge_cap_time;
		logic div_done;
	} status_t;

endpackage

### rtl/ctte_div.sv
// ----------------------------------------------------------------------------
// Charge estimator divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctte_div #(
	parameter int NUM_W = 48,
	parameter int DEN_W = 40
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo,
	output logic             done
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   shifted;
	logic [DEN_W+1:0] trial;

	// Shift in the next dividend bit and try the subtract
	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign trial   = {1'b0, shifted} - (DEN_W + 2)'(den_q);

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			if (!trial[DEN_W+1]) begin
				rem_q <= trial[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule

### rtl/ctte_datapath.sv
// ----------------------------------------------------------------------------
// Charge estimator datapath
// Sample registers, estimator state, shared multiplier and divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctte_datapath #(
	parameter int FRACTION_BITS = ctte_pkg::FRACTION_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  ctte_pkg::op_t                         op,
	output ctte_pkg::status_t                     st,
	input  logic                                  cfg_we,
	input  logic [ctte_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ctte_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic signed [ctte_pkg::CUR_IN_W-1:0]  in_current,
	input  logic [ctte_pkg::PCT_W-1:0]            in_percent,
	input  logic [ctte_pkg::TIME_W-1:0]           in_time,
	output logic                                  charging,
	output logic [31:0]                           full_in_seconds,
	output logic                                  log_valid,
	output logic [ctte_pkg::TIME_W-1:0]           log_time_ms,
	output logic [ctte_pkg::PCT_W-1:0]            log_percent,
	output logic [ctte_pkg::CHG_W-1:0]            log_charge_mams
);
	import ctte_pkg::*;

	localparam int F      = FRACTION_BITS;
	localparam int CUR_W  = 20 + F;
	localparam int RATE_W = 24 + F;
	localparam int NUM_W  = 32 + F;
	localparam int DEN_W  = 24 + F;
	localparam int AW     = 25 + F;
	localparam int BW     = 21;
	localparam int P_W    = AW + BW;
	localparam logic signed [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};
	localparam logic signed [P_W-1:0]    HALF     = P_W'(32768);
	// ceil(2^38 / 1875): elapsed * 65536 / 60000 == (elapsed * WQ_RECIP) >> 27
	localparam logic [43:0]              WQ_RECIP = 44'd146601551;

	// Configuration
	logic [TIME_W-1:0]   min_time_q;
	logic [WEIGHT_W-1:0] cur_wt_q;
	logic [WEIGHT_W-1:0] rate_wt_q;
	logic [CAP_W-1:0]    cap_q;

	// Sample
	logic signed [CUR_IN_W-1:0] cur_q;
	logic [PCT_W-1:0]           pct_q;
	logic [TIME_W-1:0]          now_q;

	// Estimator state
	logic                     was_q;
	logic [TIME_W-1:0]        prev_time_q;
	logic [PCT_W-1:0]         prev_pct_q;
	logic [PCT_W-1:0]         logged_q;
	logic [CHG_W-1:0]         gath_q;
	logic [TIME_W-1:0]        start_q;
	logic [CUR_W-1:0]         avg_cur_q;
	logic signed [RATE_W-1:0] avg_rate_q;
	logic [TIME_W-1:0]        elapsed_q;
	logic [31:0]              full_est_q;

	// Working registers
	logic signed [P_W-1:0]    prod_q;
	logic signed [P_W-1:0]    acc_q;
	logic signed [RATE_W-1:0] inst_q;
	logic [31:0]              cur_s_q;
	logic [31:0]              soc_s_q;
	logic [16:0]              wq_q;
	logic                     lg_v_q;
	logic [TIME_W-1:0]        lg_t_q;
	logic [PCT_W-1:0]         lg_p_q;
	logic [CHG_W-1:0]         lg_c_q;

	// Result registers
	logic               o_chg_q;
	logic [31:0]        o_full_q;
	logic               o_lv_q;
	logic [TIME_W-1:0]  o_lt_q;
	logic [PCT_W-1:0]   o_lp_q;
	logic [CHG_W-1:0]   o_lc_q;

	// Combinational values
	logic                     charging_w;
	logic [TIME_W-1:0]        dt;
	logic [TIME_W-1:0]        elapsed_new;
	logic signed [7:0]        diff;
	logic [PCT_W-1:0]         mag;
	logic [PCT_W-1:0]         rem;
	logic [16:0]              cur_wc;
	logic [16:0]              rate_wc;
	logic signed [AW-1:0]     mul_a;
	logic signed [BW-1:0]     mul_b;
	logic [52:0]              gsum;
	logic [CHG_W-1:0]         gs48;
	logic signed [P_W-1:0]    mix_sum;
	logic signed [P_W-1:0]    mix_sh;
	logic [31:0]              blend_sat;
	logic [28:0]              rbase;
	logic [11:0]              rem36;
	logic [31:0]              cbase;
	logic [18:0]              sbase;
	logic [43:0]              wq_prod;
	logic                     div_start;
	logic [NUM_W-1:0]         div_num;
	logic [DEN_W-1:0]         div_den;
	logic [NUM_W-1:0]         div_quo;
	logic                     div_done;
	logic [31:0]              quo_sat;
	logic signed [RATE_W-1:0] mag_r;
	logic signed [RATE_W-1:0] inst_next;
	logic [RATE_W+3:0]        rate10;

	assign charging_w  = !cur_q[CUR_IN_W-1] && (cur_q != '0);
	assign dt          = now_q - prev_time_q;
	assign elapsed_new = now_q - start_q;
	assign diff        = signed'({1'b0, pct_q}) - signed'({1'b0, prev_pct_q});
	assign mag         = diff[7] ? PCT_W'(-diff) : PCT_W'(diff);
	assign rem         = (pct_q >= 7'd100) ? '0 : 7'(7'd100 - pct_q);
	assign cur_wc      = 17'd65536 - 17'(cur_wt_q);
	assign rate_wc     = 17'd65536 - 17'(rate_wt_q);

	// Select multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (op)
			OP_MUL_GATH: begin
				mul_a = signed'(AW'(dt));
				mul_b = BW'(cur_q);
			end
			OP_MUL_AC1: begin
				mul_a = signed'(AW'(avg_cur_q));
				mul_b = signed'(BW'(cur_wc));
			end
			OP_MUL_AC2: begin
				mul_a = AW'(cur_q) <<< F;
				mul_b = signed'(BW'(cur_wt_q));
			end
			OP_MUL_RM1: begin
				mul_a = AW'(avg_rate_q);
				mul_b = signed'(BW'(rate_wc));
			end
			OP_MUL_RM2: begin
				mul_a = AW'(inst_q);
				mul_b = signed'(BW'(rate_wt_q));
			end
			OP_MUL_BL1: begin
				mul_a = signed'(AW'(soc_s_q));
				mul_b = signed'(BW'(wq_q));
			end
			OP_MUL_BL2: begin
				mul_a = signed'(AW'(cur_s_q));
				mul_b = signed'(BW'(17'd65536 - wq_q));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Saturating charge sum
	assign gsum = 53'(gath_q) + 53'(prod_q[51:0]);
	assign gs48 = (|gsum[52:48]) ? '1 : gsum[47:0];

	// Weighted mix, rounded to nearest
	assign mix_sum   = acc_q + prod_q + HALF;
	assign mix_sh    = mix_sum >>> 16;
	assign blend_sat = (|mix_sh[P_W-1:32]) ? '1 : mix_sh[31:0];

	// Dividend bases
	assign rbase = 29'(mag) * 29'd3600000;
	assign rem36 = 12'(rem) * 12'd36;
	assign cbase = 32'(rem36) * 32'(cap_q);
	assign sbase = 19'(rem) * 19'd3600;

	// Blend weight below the cap by reciprocal multiplication (elapsed under 48000 ms)
	assign wq_prod = 44'(elapsed_q[15:0]) * WQ_RECIP;

	// Launch the divider
	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		case (op)
			OP_RDIV_GO: begin
				div_start = 1'b1;
				div_num   = NUM_W'(rbase) << F;
				div_den   = DEN_W'(dt);
			end
			OP_CDIV_GO: begin
				div_start = 1'b1;
				div_num   = NUM_W'(cbase) << F;
				div_den   = DEN_W'(avg_cur_q);
			end
			OP_SDIV_GO: begin
				div_start = 1'b1;
				div_num   = NUM_W'(sbase) << F;
				div_den   = DEN_W'($unsigned(avg_rate_q));
			end
			default: begin
				div_start = 1'b0;
				div_num   = '0;
				div_den   = '0;
			end
		endcase
	end

	ctte_div #(
		.NUM_W(NUM_W),
		.DEN_W(DEN_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.quo   (div_quo),
		.done  (div_done)
	);

	// Quotient post-processing
	assign quo_sat   = (|div_quo[NUM_W-1:32]) ? '1 : div_quo[31:0];
	assign mag_r     = (|div_quo[NUM_W-1:RATE_W-1]) ? RATE_MAX
	                                              : signed'(RATE_W'(div_quo[RATE_W-2:0]));
	assign inst_next = diff[7] ? -mag_r : mag_r;
	assign rate10    = (RATE_W + 4)'($unsigned(avg_rate_q)) * (RATE_W + 4)'(10);

	// Status
	assign st.charging     = charging_w;
	assign st.chg_before   = was_q;
	assign st.ge_min       = elapsed_new >= min_time_q;
	assign st.dt_nz        = dt != '0;
	assign st.rate_zero    = avg_rate_q == '0;
	assign st.cur_zero     = avg_cur_q == '0;
	assign st.rate_usable  = !avg_rate_q[RATE_W-1] && (avg_rate_q != '0)
	                         && (rate10 > ((RATE_W + 4)'(1) << F));
	assign st.ge_cap_time  = elapsed_q >= 32'd48000;
	assign st.div_done     = div_done;

	// Configuration and estimator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_time_q  <= MIN_TIME_RST;
			cur_wt_q    <= WEIGHT_RST;
			rate_wt_q   <= WEIGHT_RST;
			cap_q       <= CAPACITY_RST;
			was_q       <= 1'b0;
			prev_time_q <= '0;
			prev_pct_q  <= '0;
			logged_q    <= '0;
			gath_q      <= '0;
			start_q     <= '0;
			avg_cur_q   <= '0;
			avg_rate_q  <= '0;
			elapsed_q   <= '0;
			full_est_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MIN_TIME:    min_time_q <= cfg_data[TIME_W-1:0];
					REG_CUR_WEIGHT:  cur_wt_q   <= cfg_data[WEIGHT_W-1:0];
					REG_RATE_WEIGHT: rate_wt_q  <= cfg_data[WEIGHT_W-1:0];
					REG_CAPACITY:    cap_q      <= cfg_data[CAP_W-1:0];
					default: ;
				endcase
			end
			case (op)
				OP_LOG: begin
					if (charging_w) begin
						if (pct_q != logged_q) begin
							gath_q   <= '0;
							logged_q <= pct_q;
						end else begin
							gath_q <= gs48;
						end
						if (!was_q) begin
							start_q    <= now_q;
							avg_cur_q  <= CUR_W'(cur_q) << F;
							avg_rate_q <= '0;
							full_est_q <= '0;
						end else begin
							elapsed_q <= elapsed_new;
						end
					end else begin
						elapsed_q  <= '0;
						full_est_q <= '0;
						avg_rate_q <= '0;
						gath_q     <= '0;
						logged_q   <= prev_pct_q;
					end
				end
				OP_AC3:      avg_cur_q  <= mix_sh[CUR_W-1:0];
				OP_RATE_SET: avg_rate_q <= inst_q;
				OP_RATE_MIX: avg_rate_q <= mix_sh[RATE_W-1:0];
				OP_FULL_CUR: full_est_q <= cur_s_q;
				OP_BLEND:    full_est_q <= blend_sat;
				OP_FIN: begin
					was_q       <= charging_w;
					prev_time_q <= now_q;
					prev_pct_q  <= pct_q;
				end
				default: ;
			endcase
		end
	end

	// Working and result registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (op)
			OP_LOAD: begin
				cur_q <= in_current;
				pct_q <= in_percent;
				now_q <= in_time;
			end
			OP_LOG: begin
				if (charging_w && (pct_q != logged_q)) begin
					lg_v_q <= 1'b1;
					lg_t_q <= now_q;
					lg_p_q <= pct_q;
					lg_c_q <= gs48;
				end else begin
					lg_v_q <= 1'b0;
					lg_t_q <= '0;
					lg_p_q <= '0;
					lg_c_q <= '0;
				end
			end
			OP_MUL_AC2, OP_MUL_RM2, OP_MUL_BL2: acc_q <= prod_q;
			OP_RDIV_TAKE: inst_q  <= inst_next;
			OP_CUR_SAT:   cur_s_q <= '1;
			OP_CDIV_TAKE: cur_s_q <= quo_sat;
			OP_SDIV_TAKE: soc_s_q <= quo_sat;
			OP_WQ_CAP:    wq_q    <= 17'd52429;
			OP_WQ_CALC:   wq_q    <= wq_prod[43:27];
			OP_FIN: begin
				o_chg_q  <= charging_w;
				o_full_q <= full_est_q;
				o_lv_q   <= lg_v_q;
				o_lt_q   <= lg_t_q;
				o_lp_q   <= lg_p_q;
				o_lc_q   <= lg_c_q;
			end
			default: ;
		endcase
	end

	assign charging        = o_chg_q;
	assign full_in_seconds = o_full_q;
	assign log_valid       = o_lv_q;
	assign log_time_ms     = o_lt_q;
	assign log_percent     = o_lp_q;
	assign log_charge_mams = o_lc_q;

endmodule

### rtl/ctte_ctrl.sv
// ----------------------------------------------------------------------------
// Charge estimator controller
// Sequences one sample through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctte_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  ctte_pkg::status_t st,
	output ctte_pkg::op_t     op
);
	import ctte_pkg::*;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_GATH = 5'd1;
	localparam logic [4:0] S_LOG  = 5'd2;
	localparam logic [4:0] S_AC1  = 5'd3;
	localparam logic [4:0] S_AC2  = 5'd4;
	localparam logic [4:0] S_AC3  = 5'd5;
	localparam logic [4:0] S_RDIV = 5'd6;
	localparam logic [4:0] S_RDW  = 5'd7;
	localparam logic [4:0] S_RSEL = 5'd8;
	localparam logic [4:0] S_RM2  = 5'd9;
	localparam logic [4:0] S_RM3  = 5'd10;
	localparam logic [4:0] S_TTF  = 5'd11;
	localparam logic [4:0] S_CDW  = 5'd12;
	localparam logic [4:0] S_CHK  = 5'd13;
	localparam logic [4:0] S_SDW  = 5'd14;
	localparam logic [4:0] S_WQ   = 5'd15;
	localparam logic [4:0] S_BL1  = 5'd16;
	localparam logic [4:0] S_BL2  = 5'd17;
	localparam logic [4:0] S_BL3  = 5'd18;
	localparam logic [4:0] S_FIN  = 5'd19;

	logic [4:0] state_q;
	logic [4:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;

	// Next state and datapath operation
	always_comb begin
		state_d = state_q;
		op      = OP_NOP;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op      = OP_LOAD;
					state_d = S_GATH;
				end
			end
			S_GATH: begin
				op      = OP_MUL_GATH;
				state_d = S_LOG;
			end
			S_LOG: begin
				op = OP_LOG;
				if (st.charging && st.chg_before && st.ge_min) begin
					state_d = S_AC1;
				end else begin
					state_d = S_FIN;
				end
			end
			S_AC1: begin
				op      = OP_MUL_AC1;
				state_d = S_AC2;
			end
			S_AC2: begin
				op      = OP_MUL_AC2;
				state_d = S_AC3;
			end
			S_AC3: begin
				op      = OP_AC3;
				state_d = st.dt_nz ? S_RDIV : S_TTF;
			end
			S_RDIV: begin
				op      = OP_RDIV_GO;
				state_d = S_RDW;
			end
			S_RDW: begin
				if (st.div_done) begin
					op      = OP_RDIV_TAKE;
					state_d = S_RSEL;
				end
			end
			S_RSEL: begin
				if (st.rate_zero) begin
					op      = OP_RATE_SET;
					state_d = S_TTF;
				end else begin
					op      = OP_MUL_RM1;
					state_d = S_RM2;
				end
			end
			S_RM2: begin
				op      = OP_MUL_RM2;
				state_d = S_RM3;
			end
			S_RM3: begin
				op      = OP_RATE_MIX;
				state_d = S_TTF;
			end
			S_TTF: begin
				if (st.cur_zero) begin
					op      = OP_CUR_SAT;
					state_d = S_CHK;
				end else begin
					op      = OP_CDIV_GO;
					state_d = S_CDW;
				end
			end
			S_CDW: begin
				if (st.div_done) begin
					op      = OP_CDIV_TAKE;
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				if (st.rate_usable) begin
					op      = OP_SDIV_GO;
					state_d = S_SDW;
				end else begin
					op      = OP_FULL_CUR;
					state_d = S_FIN;
				end
			end
			S_SDW: begin
				if (st.div_done) begin
					op      = OP_SDIV_TAKE;
					state_d = S_WQ;
				end
			end
			S_WQ: begin
				if (st.ge_cap_time) begin
					op = OP_WQ_CAP;
				end else begin
					op = OP_WQ_CALC;
				end
				state_d = S_BL1;
			end
			S_BL1: begin
				op      = OP_MUL_BL1;
				state_d = S_BL2;
			end
			S_BL2: begin
				op      = OP_MUL_BL2;
				state_d = S_BL3;
			end
			S_BL3: begin
				op      = OP_BLEND;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (out_free) begin
					op      = OP_FIN;
					state_d = S_IDLE;
				end
			end
			default: begin
				op      = OP_NOP;
				state_d = S_IDLE;
			end
		endcase
	end

	// State and output beat flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

endmodule

### rtl/charge_time_to_full_estimator.sv
// ----------------------------------------------------------------------------
// Charge time-to-full estimator
// Integrates charging current, logs percent changes and estimates seconds to
// full from moving averages of current and percent-per-hour rate.
//
//   channel  handshake                 payload
//   in       in_valid / in_ready       current_ma, charge_percent, time_ms
//   out      out_valid / out_ready     charging, full_in_seconds, log_*
//   cfg      cfg_we (no wait)          cfg_index, cfg_data
//
// A sample that does not update the averages passes only the gather, log and
// finish steps, its result registered in the finish step. A full update adds
// the average steps and, where they apply, the rate and blend steps, and waits
// on the bit-serial divider that serves the rate, current-based and rate-based
// divisions in turn.
// Reset clears all estimator state and loads the register defaults.
// A stalled result holds in the output register; the next sample is taken
// meanwhile and waits in its last step until that beat is gone.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "charge_time_to_full_estimator_macros.svh"

module charge_time_to_full_estimator #(
	parameter int FRACTION_BITS = ctte_pkg::FRACTION_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [ctte_pkg::CUR_IN_W-1:0] current_ma,
	input  logic [ctte_pkg::PCT_W-1:0]           charge_percent,
	input  logic [ctte_pkg::TIME_W-1:0]          time_ms,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 charging,
	output logic [31:0]                          full_in_seconds,
	output logic                                 log_valid,
	output logic [ctte_pkg::TIME_W-1:0]          log_time_ms,
	output logic [ctte_pkg::PCT_W-1:0]           log_percent,
	output logic [ctte_pkg::CHG_W-1:0]           log_charge_mams,
	input  logic                                 cfg_we,
	input  logic [ctte_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ctte_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import ctte_pkg::*;

	op_t     op;
	status_t st;

	// Sequencer
	ctte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.st       (st),
		.op       (op)
	);

	// Arithmetic and state
	ctte_datapath #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.op             (op),
		.st             (st),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_current     (current_ma),
		.in_percent     (charge_percent),
		.in_time        (time_ms),
		.charging       (charging),
		.full_in_seconds(full_in_seconds),
		.log_valid      (log_valid),
		.log_time_ms    (log_time_ms),
		.log_percent    (log_percent),
		.log_charge_mams(log_charge_mams)
	);

	// Assertions
	`CTTE_ASSERT(a_idle_full_zero, (out_valid && !charging) |-> (full_in_seconds == 32'd0))
	`CTTE_ASSERT(a_log_needs_charge, (out_valid && log_valid) |-> charging)
	`CTTE_ASSERT(a_nolog_zero, (out_valid && !log_valid) |-> !(|{log_time_ms, log_percent}))
	`CTTE_ASSERT(a_nolog_chg_zero, (out_valid && !log_valid) |-> (log_charge_mams == '0))
	`CTTE_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

endmodule
